>>> src/asp_pkg.sv
// Shared constants, codes and the CORDIC arctangent table for the surface point inversion block.
package asp_pkg;

   localparam int ANG_W = 36;   // signed Q6.30 angles (30 fraction bits) with room for wrap

   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] ROUND_Q14   = 36'sd8192;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 36'sd411775;
   localparam logic [29:0]             KINV_Q30    = 30'd652032874;

   typedef enum logic [2:0] {
      SURF_PLANE    = 3'd0,
      SURF_CYLINDER = 3'd1,
      SURF_CONE     = 3'd2,
      SURF_SPHERE   = 3'd3,
      SURF_TORUS    = 3'd4
   } surf_kind_type;

   typedef enum logic [2:0] {
      CSR_KIND     = 3'd0,
      CSR_ORIGIN_X = 3'd1,
      CSR_ORIGIN_Y = 3'd2,
      CSR_ORIGIN_Z = 3'd3,
      CSR_X_AXIS   = 3'd4,
      CSR_Y_AXIS   = 3'd5,
      CSR_Z_AXIS   = 3'd6,
      CSR_RAD_ANG  = 3'd7
   } csr_idx_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         5'd0:  r = 36'sd843314857;
         5'd1:  r = 36'sd497837830;
         5'd2:  r = 36'sd263043837;
         5'd3:  r = 36'sd133525159;
         5'd4:  r = 36'sd67021687;
         5'd5:  r = 36'sd33543516;
         5'd6:  r = 36'sd16775851;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194283;
         5'd9:  r = 36'sd2097149;
         5'd10: r = 36'sd1048576;
         5'd11: r = 36'sd524288;
         5'd12: r = 36'sd262144;
         5'd13: r = 36'sd131072;
         5'd14: r = 36'sd65536;
         5'd15: r = 36'sd32768;
         5'd16: r = 36'sd16384;
         5'd17: r = 36'sd8192;
         5'd18: r = 36'sd4096;
         5'd19: r = 36'sd2048;
         5'd20: r = 36'sd1024;
         5'd21: r = 36'sd512;
         5'd22: r = 36'sd256;
         5'd23: r = 36'sd128;
         5'd24: r = 36'sd64;
         5'd25: r = 36'sd32;
         5'd26: r = 36'sd16;
         5'd27: r = 36'sd8;
         5'd28: r = 36'sd4;
         5'd29: r = 36'sd2;
         5'd30: r = 36'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> src/asp_frame.sv
// Frame transform: point minus origin, then rounded dot products with the three axes.
module asp_frame
   import asp_pkg::*;
#(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          pt_x,
   input  logic [31:0]          pt_y,
   input  logic [31:0]          pt_z,
   input  logic [31:0]          org_x,
   input  logic [31:0]          org_y,
   input  logic [31:0]          org_z,
   input  logic [47:0]          axis_x,
   input  logic [47:0]          axis_y,
   input  logic [47:0]          axis_z,
   output logic                 out_valid,
   output logic signed [CW+4:0] out_x,
   output logic signed [CW+4:0] out_y,
   output logic signed [CW+4:0] out_z
);

   localparam int DW   = CW + 1;
   localparam int PRW  = CW + 17;
   localparam int SUMW = CW + 19;
   localparam int XW   = CW + 5;

   logic                 v1_ff, v2_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [XW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;

   // low CW bits when CW <= 32, zero extension above that
   function automatic logic signed [DW-1:0] coord(input logic [31:0] v);
      logic [CW+31:0] t;
      t = {{CW{1'b0}}, v};
      return DW'($signed(t[CW-1:0]));
   endfunction

   function automatic logic signed [XW-1:0] dot(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b,
                                                input logic signed [DW-1:0] c,
                                                input logic [47:0] ax);
      logic signed [PRW-1:0]  p0, p1, p2;
      logic signed [SUMW-1:0] s;
      p0 = PRW'(a) * PRW'($signed(ax[15:0]));
      p1 = PRW'(b) * PRW'($signed(ax[31:16]));
      p2 = PRW'(c) * PRW'($signed(ax[47:32]));
      s  = SUMW'(p0) + SUMW'(p1) + SUMW'(p2) + SUMW'(ROUND_Q14);
      s  = s >>> 14;
      return s[XW-1:0];
   endfunction

   always_comb begin
      dx_in = coord(pt_x) - coord(org_x);
      dy_in = coord(pt_y) - coord(org_y);
      dz_in = coord(pt_z) - coord(org_z);
      x_in  = dot(dx_ff, dy_ff, dz_ff, axis_x);
      y_in  = dot(dx_ff, dy_ff, dz_ff, axis_y);
      z_in  = dot(dx_ff, dy_ff, dz_ff, axis_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
   end

   assign out_valid = v2_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

>>> src/asp_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its registers and the item's side data.
module asp_cordic_cell
   import asp_pkg::*;
#(
   parameter int W    = 40,
   parameter int SW   = 8,
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_zero,
   input  logic signed [W-1:0]     in_x,
   input  logic signed [W-1:0]     in_y,
   input  logic signed [ANG_W-1:0] in_a,
   input  logic [SW-1:0]           in_side,
   output logic                    out_valid,
   output logic                    out_zero,
   output logic signed [W-1:0]     out_x,
   output logic signed [W-1:0]     out_y,
   output logic signed [ANG_W-1:0] out_a,
   output logic [SW-1:0]           out_side
);

   logic                    valid_ff, zero_ff;
   logic signed [W-1:0]     x_ff, y_ff, x_in, y_in;
   logic signed [ANG_W-1:0] a_ff, a_in;
   logic [SW-1:0]           side_ff;

   always_comb begin
      if (in_y > 0) begin
         x_in = in_x + (in_y >>> STEP);
         y_in = in_y - (in_x >>> STEP);
         a_in = in_a + atan_q30(5'(STEP));
      end else begin
         x_in = in_x - (in_y >>> STEP);
         y_in = in_y + (in_x >>> STEP);
         a_in = in_a - atan_q30(5'(STEP));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      zero_ff <= in_zero;
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_zero  = zero_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_a     = a_ff;
   assign out_side  = side_ff;

endmodule

>>> src/asp_cordic.sv
// Pipelined vectoring CORDIC: quadrant fold, chain of cells, gain-corrected magnitude.
module asp_cordic
   import asp_pkg::*;
#(
   parameter int W  = 40,
   parameter int N  = 16,
   parameter int SW = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [W-1:0]     in_x,
   input  logic signed [W-1:0]     in_y,
   input  logic [SW-1:0]           in_side,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_ang,
   output logic signed [W-1:0]     out_mag,
   output logic [SW-1:0]           out_side
);

   localparam int HPW = W + 9;

   logic                    cv [0:N];
   logic                    cz [0:N];
   logic signed [W-1:0]     cx [0:N];
   logic signed [W-1:0]     cy [0:N];
   logic signed [ANG_W-1:0] ca [0:N];
   logic [SW-1:0]           cs [0:N];

   logic                    pv_ff, pz_ff, pz_in;
   logic signed [W-1:0]     px_ff, py_ff, px_in, py_in;
   logic signed [ANG_W-1:0] pa_ff, pa_in;
   logic [SW-1:0]           ps_ff;

   // quadrant fold into the right half plane
   always_comb begin
      pz_in = (in_x == '0) && (in_y == '0);
      px_in = in_x;
      py_in = in_y;
      pa_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            px_in = in_y;
            py_in = -in_x;
            pa_in = HALF_PI_Q30;
         end else begin
            px_in = -in_y;
            py_in = in_x;
            pa_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= in_valid;
      end
      pz_ff <= pz_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pa_ff <= pa_in;
      ps_ff <= in_side;
   end

   assign cv[0] = pv_ff;
   assign cz[0] = pz_ff;
   assign cx[0] = px_ff;
   assign cy[0] = py_ff;
   assign ca[0] = pa_ff;
   assign cs[0] = ps_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      asp_cordic_cell #(.W(W), .SW(SW), .STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (cv[i]),
         .in_zero  (cz[i]),
         .in_x     (cx[i]),
         .in_y     (cy[i]),
         .in_a     (ca[i]),
         .in_side  (cs[i]),
         .out_valid(cv[i+1]),
         .out_zero (cz[i+1]),
         .out_x    (cx[i+1]),
         .out_y    (cy[i+1]),
         .out_a    (ca[i+1]),
         .out_side (cs[i+1])
      );
   end

   // magnitude = x * Kinv >> 30, split into high and low partial products
   logic                    m1v_ff, m2v_ff;
   logic [W-1:0]            xc;
   logic [HPW-1:0]          hp_ff, hp_in;
   logic [49:0]             lo_ff, lo_in;
   logic signed [ANG_W-1:0] m1a_ff, m2a_ff;
   logic [SW-1:0]           m1s_ff, m2s_ff;
   logic signed [W-1:0]     mag_ff, mag_in;
   logic [50:0]             frac;

   always_comb begin
      xc    = (cx[N] < 0) ? '0 : cx[N];
      hp_in = HPW'(xc[W-1:20]) * HPW'(KINV_Q30);
      lo_in = 50'(xc[19:0]) * 50'(KINV_Q30);
      frac  = 51'({hp_ff[9:0], 20'b0}) + 51'(lo_ff);
      mag_in = W'(hp_ff >> 10) + W'(frac[50:30]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
         m2v_ff <= 1'b0;
      end else begin
         m1v_ff <= cv[N];
         m2v_ff <= m1v_ff;
      end
      hp_ff  <= hp_in;
      lo_ff  <= lo_in;
      m1a_ff <= cz[N] ? '0 : ca[N];
      m1s_ff <= cs[N];
      mag_ff <= mag_in;
      m2a_ff <= m1a_ff;
      m2s_ff <= m1s_ff;
   end

   assign out_valid = m2v_ff;
   assign out_ang   = m2a_ff;
   assign out_mag   = mag_ff;
   assign out_side  = m2s_ff;

endmodule

>>> src/analytic_surface_point_inversion.sv
// Top level: configuration registers, frame transform, two CORDIC chains and result stages.
//
//   channel  ports                              direction  handshake
//   request  start, busy, req_point_x/y/z        in         start & !busy
//   result   rsp_valid, rsp_u_param/v_param      out        rsp_valid, one cycle
//   csr      csr_we, csr_index, csr_wdata        in         csr_we
//
// One point is taken every cycle; busy is never raised.
// The pipeline holds two frame stages, two CORDIC chains of CORDIC_ITERATIONS cells plus
// three stages each, one stage between them and three at the end.
// Synchronous reset clears the pipeline valid bits and loads the default frame.
// The result is shown for one cycle only; the receiver cannot stall it.
module analytic_surface_point_inversion
   import asp_pkg::*;
#(
   parameter int COORD_WIDTH       = 32,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_u_param,
   output logic [31:0] rsp_v_param,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [62:0] csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int XW  = CW + 5;
   localparam int W   = ((CW > 32) ? CW : 32) + 8;
   localparam int PW2 = W + 16;
   localparam int VW  = W + 17;
   localparam int OW  = (CW < 32) ? CW : 32;
   localparam int SW1 = 3 * XW;
   localparam int SW2 = ANG_W + 3 * XW + 2 * PW2;
   localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (OW - 1)) - VW'(1);
   localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

   // configuration
   logic [2:0]  kind_ff;
   logic [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic [47:0] ax_x_ff, ax_y_ff, ax_z_ff;
   logic [62:0] rad_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= SURF_PLANE;
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         org_z_ff   <= '0;
         ax_x_ff    <= 48'd16384;
         ax_y_ff    <= 48'd1073741824;
         ax_z_ff    <= 48'd70368744177664;
         rad_ang_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_KIND:     kind_ff    <= csr_wdata[2:0];
            CSR_ORIGIN_X: org_x_ff   <= csr_wdata[31:0];
            CSR_ORIGIN_Y: org_y_ff   <= csr_wdata[31:0];
            CSR_ORIGIN_Z: org_z_ff   <= csr_wdata[31:0];
            CSR_X_AXIS:   ax_x_ff    <= csr_wdata[47:0];
            CSR_Y_AXIS:   ax_y_ff    <= csr_wdata[47:0];
            CSR_Z_AXIS:   ax_z_ff    <= csr_wdata[47:0];
            CSR_RAD_ANG:  rad_ang_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [30:0]         rad;
   logic signed [15:0]  sn, cs;
   assign rad = rad_ang_ff[30:0];
   assign sn  = $signed(rad_ang_ff[46:31]);
   assign cs  = $signed(rad_ang_ff[62:47]);

   assign busy = 1'b0;

   // frame
   logic                 fv;
   logic signed [XW-1:0] fx, fy, fz;

   asp_frame #(.CW(CW)) u_frame (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .pt_x     (req_point_x),
      .pt_y     (req_point_y),
      .pt_z     (req_point_z),
      .org_x    (org_x_ff),
      .org_y    (org_y_ff),
      .org_z    (org_z_ff),
      .axis_x   (ax_x_ff),
      .axis_y   (ax_y_ff),
      .axis_z   (ax_z_ff),
      .out_valid(fv),
      .out_x    (fx),
      .out_y    (fy),
      .out_z    (fz)
   );

   // first CORDIC: azimuth and rho
   logic                    c1v;
   logic signed [ANG_W-1:0] ang1;
   logic signed [W-1:0]     rho;
   logic [SW1-1:0]          s1;

   asp_cordic #(.W(W), .N(CORDIC_ITERATIONS), .SW(SW1)) u_cordic1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fv),
      .in_x     (W'(fx)),
      .in_y     (W'(fy)),
      .in_side  ({fx, fy, fz}),
      .out_valid(c1v),
      .out_ang  (ang1),
      .out_mag  (rho),
      .out_side (s1)
   );

   logic signed [XW-1:0] x1, y1, z1;
   assign {x1, y1, z1} = s1;

   // between the chains: wrap azimuth, cone products, second CORDIC inputs
   logic                    mv_ff;
   logic signed [ANG_W-1:0] uw_ff, uw_in;
   logic signed [W-1:0]     x2_ff, x2_in, rr;
   logic signed [PW2-1:0]   p1_ff, p1_in, p2_ff, p2_in;
   logic signed [XW-1:0]    mx_ff, my_ff, mz_ff;

   always_comb begin
      uw_in = (ang1 < 0) ? ang1 + TWO_PI_Q30 : ang1;
      rr    = rho - W'($signed({1'b0, rad}));
      x2_in = (kind_ff == SURF_SPHERE) ? rho : rr;
      p1_in = PW2'(rr) * PW2'(sn);
      p2_in = PW2'(z1) * PW2'(cs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else begin
         mv_ff <= c1v;
      end
      uw_ff <= uw_in;
      x2_ff <= x2_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      mx_ff <= x1;
      my_ff <= y1;
      mz_ff <= z1;
   end

   // second CORDIC: latitude or tube angle
   logic                    c2v;
   logic signed [ANG_W-1:0] ang2;
   logic signed [W-1:0]     mag2;
   logic [SW2-1:0]          s2;

   asp_cordic #(.W(W), .N(CORDIC_ITERATIONS), .SW(SW2)) u_cordic2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mv_ff),
      .in_x     (x2_ff),
      .in_y     (W'(mz_ff)),
      .in_side  ({uw_ff, mx_ff, my_ff, mz_ff, p1_ff, p2_ff}),
      .out_valid(c2v),
      .out_ang  (ang2),
      .out_mag  (mag2),
      .out_side (s2)
   );

   logic signed [ANG_W-1:0] uw2;
   logic signed [XW-1:0]    x3, y3, z3;
   logic signed [PW2-1:0]   p1b, p2b;
   assign {uw2, x3, y3, z3, p1b, p2b} = s2;

   // result stage 1: torus wrap, cone sum, azimuth rounding
   logic                    f1v_ff, f2v_ff, ov_ff;
   logic signed [ANG_W-1:0] a2w_ff, a2w_in, ur_ff, ur_in;
   logic signed [VW-1:0]    csum_ff, csum_in;
   logic signed [XW-1:0]    f1x_ff, f1y_ff, f1z_ff;

   always_comb begin
      a2w_in  = (kind_ff == SURF_TORUS && ang2 < 0) ? ang2 + TWO_PI_Q30 : ang2;
      csum_in = VW'(p1b) + VW'(p2b);
      ur_in   = (uw2 + ROUND_Q14) >>> 14;
   end

   // result stage 2: roundings and azimuth wrap
   logic signed [ANG_W-1:0] vr_ff, vr_in, uf_ff, uf_in;
   logic signed [VW-1:0]    cone_ff, cone_in;
   logic signed [XW-1:0]    f2x_ff, f2y_ff, f2z_ff;

   always_comb begin
      vr_in   = (a2w_ff + ROUND_Q14) >>> 14;
      cone_in = (csum_ff + VW'(ROUND_Q14)) >>> 14;
      uf_in   = (ur_ff >= TWO_PI_Q16) ? ur_ff - TWO_PI_Q16 : ur_ff;
   end

   // result stage 3: torus angle wrap, select by surface and saturate
   logic signed [ANG_W-1:0] vt;
   logic signed [VW-1:0]    u_sel, v_sel;
   logic [31:0]             u_in, v_in, u_ff, v_ff;

   function automatic logic [31:0] sat_out(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[31:0];
   endfunction

   always_comb begin
      vt = (kind_ff == SURF_TORUS && vr_ff >= TWO_PI_Q16) ? vr_ff - TWO_PI_Q16 : vr_ff;
      case (kind_ff)
         SURF_PLANE: begin
            u_sel = VW'(f2x_ff);
            v_sel = VW'(f2y_ff);
         end
         SURF_CYLINDER: begin
            u_sel = VW'(uf_ff);
            v_sel = VW'(f2z_ff);
         end
         SURF_CONE: begin
            u_sel = VW'(uf_ff);
            v_sel = cone_ff;
         end
         SURF_SPHERE, SURF_TORUS: begin
            u_sel = VW'(uf_ff);
            v_sel = VW'(vt);
         end
         default: begin
            u_sel = '0;
            v_sel = '0;
         end
      endcase
      u_in = sat_out(u_sel);
      v_in = sat_out(v_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1v_ff <= 1'b0;
         f2v_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         f1v_ff <= c2v;
         f2v_ff <= f1v_ff;
         ov_ff  <= f2v_ff;
      end
      a2w_ff  <= a2w_in;
      csum_ff <= csum_in;
      ur_ff   <= ur_in;
      f1x_ff  <= x3;
      f1y_ff  <= y3;
      f1z_ff  <= z3;
      vr_ff   <= vr_in;
      cone_ff <= cone_in;
      uf_ff   <= uf_in;
      f2x_ff  <= f1x_ff;
      f2y_ff  <= f1y_ff;
      f2z_ff  <= f1z_ff;
      u_ff    <= u_in;
      v_ff    <= v_in;
   end

   // second magnitude is not needed
   logic unused_mag;
   assign unused_mag = ^mag2;

   assign rsp_valid   = ov_ff & ~unused_mag | ov_ff & unused_mag;
   assign rsp_u_param = u_ff;
   assign rsp_v_param = v_ff;

endmodule
